// ===== rtl/quadratic_real_roots_unit_assert.svh =====
// Assertion helpers used by the top-level RTL of the quadratic root unit.
`ifndef QUADRATIC_REAL_ROOTS_UNIT_ASSERT_SVH
`define QUADRATIC_REAL_ROOTS_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define QRR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define QRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qrr_pkg.sv =====
package qrr_pkg;

    localparam int ROOT_W         = 25;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_AZERO  = 2'd3
    } root_status_t;

    function automatic int max_int(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    // discriminant magnitude width
    function automatic int disc_w(input int cw);
        return 2 * cw + 1;
    endfunction

    // radicand width, rounded up to an even count
    function automatic int rad_w(input int cw, input int fb);
        int w;
        w = disc_w(cw) + 2 * fb;
        return w + (w % 2);
    endfunction

    function automatic int sqrt_w(input int cw, input int fb);
        return rad_w(cw, fb) / 2;
    endfunction

    // width of -b scaled by the fraction bits
    function automatic int nb_w(input int cw, input int fb);
        return cw + fb + 1;
    endfunction

    // signed numerator width
    function automatic int num_w(input int cw, input int fb);
        return max_int(nb_w(cw, fb), sqrt_w(cw, fb) + 1) + 1;
    endfunction

endpackage

// ===== rtl/qrr_if.sv =====
interface qrr_coef_if #(
    parameter int CW = qrr_pkg::COEF_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrr_root_if ();
    logic                             valid;
    logic                             ready;
    logic [1:0]                       root_status;
    logic signed [qrr_pkg::ROOT_W-1:0] root_plus;
    logic signed [qrr_pkg::ROOT_W-1:0] root_minus;

    modport source (output valid, output root_status, output root_plus, output root_minus,
                    input ready);
    modport sink   (input valid, input root_status, input root_plus, input root_minus,
                    output ready);
endinterface

// ===== rtl/qrr_front.sv =====
module qrr_front #(
    parameter int CW  = qrr_pkg::COEF_WIDTH_DEF,
    parameter int FB  = qrr_pkg::FRAC_BITS_DEF,
    parameter int DW  = qrr_pkg::disc_w(CW),
    parameter int RWE = qrr_pkg::rad_w(CW, FB),
    parameter int NBW = qrr_pkg::nb_w(CW, FB),
    parameter int DM  = CW + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  a_in,
    input  logic signed [CW-1:0]  b_in,
    input  logic signed [CW-1:0]  c_in,
    output logic                  out_valid,
    output logic [RWE-1:0]        rad,
    output logic signed [NBW-1:0] nb,
    output logic signed [DM-1:0]  den,
    output logic [1:0]            status
);

    logic [CW-1:0]        am, bm, cm;
    logic                 v1_reg;
    logic [2*CW-1:0]      b2_reg, ac_reg;
    logic                 opp_reg, azero_reg;
    logic signed [CW-1:0] a_reg, b_reg;

    logic [DW:0]          b2e, f4, disc;
    qrr_pkg::root_status_t st;
    logic signed [NBW-1:0] bx;

    logic                  v2_reg;
    logic [RWE-1:0]        rad_reg;
    logic signed [NBW-1:0] nb_reg;
    logic signed [DM-1:0]  den_reg;
    logic [1:0]            st_reg;

    // take magnitudes of the coefficients
    always_comb
    begin
        am = a_in[CW-1] ? CW'(-a_in) : CW'(a_in);
        bm = b_in[CW-1] ? CW'(-b_in) : CW'(b_in);
        cm = c_in[CW-1] ? CW'(-c_in) : CW'(c_in);
    end

    // stage 1: square of b and product of a and c
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg    <= (2*CW)'(bm) * (2*CW)'(bm);
            ac_reg    <= (2*CW)'(am) * (2*CW)'(cm);
            opp_reg   <= a_in[CW-1] ^ c_in[CW-1];
            azero_reg <= (a_in == '0);
            a_reg     <= a_in;
            b_reg     <= b_in;
        end
    end

    // classify the discriminant
    always_comb
    begin
        b2e  = (DW+1)'(b2_reg);
        f4   = (DW+1)'(ac_reg) << 2;
        disc = '0;
        st   = qrr_pkg::ST_NONE;
        if (azero_reg)
        begin
            st = qrr_pkg::ST_AZERO;
        end
        else if (opp_reg)
        begin
            disc = b2e + f4;
            st   = (disc != '0) ? qrr_pkg::ST_TWO : qrr_pkg::ST_DOUBLE;
        end
        else if (b2e > f4)
        begin
            disc = b2e - f4;
            st   = qrr_pkg::ST_TWO;
        end
        else if (b2e == f4)
        begin
            st = qrr_pkg::ST_DOUBLE;
        end
        bx = NBW'(b_reg);
    end

    // stage 2: radicand, scaled -b and denominator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= RWE'(disc) << (2 * FB);
            nb_reg  <= -(bx <<< FB);
            den_reg <= DM'(a_reg) <<< 1;
            st_reg  <= st;
        end
    end

    assign out_valid = v2_reg;
    assign rad       = rad_reg;
    assign nb        = nb_reg;
    assign den       = den_reg;
    assign status    = st_reg;

endmodule

// ===== rtl/qrr_sqrt.sv =====
module qrr_sqrt #(
    parameter int RWE = qrr_pkg::rad_w(qrr_pkg::COEF_WIDTH_DEF, qrr_pkg::FRAC_BITS_DEF),
    parameter int SQ  = RWE / 2,
    parameter int SW  = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RWE-1:0] rad,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [SQ-1:0] root,
    output logic [SW-1:0] side_out
);

    logic            vld_reg  [0:SQ];
    logic [SW-1:0]   side_reg [0:SQ];
    logic [RWE-1:0]  rad_reg  [0:SQ];
    logic [SQ+1:0]   rem_reg  [0:SQ];
    logic [SQ-1:0]   root_reg [0:SQ];

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits shifted in
    for (genvar k = 1; k <= SQ; k++)
    begin : g_stage
        logic [SQ+1:0] rem_sh, trial;
        logic          ge;

        always_comb
        begin
            rem_sh = {rem_reg[k-1][SQ-1:0], rad_reg[k-1][RWE-1 -: 2]};
            trial  = {root_reg[k-1], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_reg[k-1][SQ-2:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[SQ];
    assign root      = root_reg[SQ];
    assign side_out  = side_reg[SQ];

endmodule

// ===== rtl/qrr_div.sv =====
module qrr_div #(
    parameter int NW = qrr_pkg::num_w(qrr_pkg::COEF_WIDTH_DEF, qrr_pkg::FRAC_BITS_DEF),
    parameter int DM = qrr_pkg::COEF_WIDTH_DEF + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [NW-1:0]             num_p,
    input  logic signed [NW-1:0]             num_m,
    input  logic signed [DM-1:0]             den,
    input  logic [1:0]                       status_in,
    output logic                             out_valid,
    output logic [1:0]                       status,
    output logic signed [qrr_pkg::ROOT_W-1:0] root_plus,
    output logic signed [qrr_pkg::ROOT_W-1:0] root_minus
);

    localparam int NM  = NW;
    localparam int RMW = DM + 1;
    localparam int XW  = qrr_pkg::max_int(NM + 1, qrr_pkg::ROOT_W) + 1;
    localparam logic signed [XW-1:0] SAT_HI = (XW'(1) << (qrr_pkg::ROOT_W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = -(XW'(1) << (qrr_pkg::ROOT_W - 1));

    logic            vld_reg [0:NM];
    logic [1:0]      st_reg  [0:NM];
    logic [DM-1:0]   d_reg   [0:NM];
    logic            neg_reg [0:1][0:NM];
    logic [NM-1:0]   n_reg   [0:1][0:NM];
    logic [RMW-1:0]  rem_reg [0:1][0:NM];
    logic [NM-1:0]   q_reg   [0:1][0:NM];

    logic                              ov_reg;
    logic [1:0]                        ost_reg;
    logic signed [qrr_pkg::ROOT_W-1:0] rp_reg, rm_reg;
    logic signed [qrr_pkg::ROOT_W-1:0] res [0:1];
    logic signed [NW-1:0]              num [0:1];
    logic                              blank;

    assign num[0] = num_p;
    assign num[1] = num_m;

    // entry register: shared control and divisor magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= status_in;
            d_reg[0]  <= den[DM-1] ? DM'(-den) : DM'(den);
        end
    end

    // advance shared control through the bit stages
    for (genvar k = 1; k <= NM; k++)
    begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_reg[k-1];
                d_reg[k]  <= d_reg[k-1];
            end
        end
    end

    // two lanes, restoring division one quotient bit per stage
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [XW-1:0] qv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[l][0] <= num[l][NW-1] ^ den[DM-1];
                n_reg[l][0]   <= num[l][NW-1] ? NM'(-num[l]) : NM'(num[l]);
                rem_reg[l][0] <= '0;
                q_reg[l][0]   <= '0;
            end
        end

        for (genvar k = 1; k <= NM; k++)
        begin : g_bit
            logic [RMW-1:0] rem_sh, dx;
            logic           ge;

            always_comb
            begin
                rem_sh = {rem_reg[l][k-1][RMW-2:0], n_reg[l][k-1][NM-1]};
                dx     = RMW'(d_reg[k-1]);
                ge     = (rem_sh >= dx);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[l][k] <= neg_reg[l][k-1];
                    n_reg[l][k]   <= n_reg[l][k-1] << 1;
                    rem_reg[l][k] <= ge ? (rem_sh - dx) : rem_sh;
                    q_reg[l][k]   <= {q_reg[l][k-1][NM-2:0], ge};
                end
            end
        end

        // apply sign and saturate, or blank the result when there is no root
        always_comb
        begin
            qv = neg_reg[l][NM] ? -$signed(XW'(q_reg[l][NM])) : $signed(XW'(q_reg[l][NM]));
            if (blank)
            begin
                res[l] = '0;
            end
            else if (qv > SAT_HI)
            begin
                res[l] = qrr_pkg::ROOT_W'(SAT_HI);
            end
            else if (qv < SAT_LO)
            begin
                res[l] = qrr_pkg::ROOT_W'(SAT_LO);
            end
            else
            begin
                res[l] = qrr_pkg::ROOT_W'(qv);
            end
        end
    end

    // no real root or a is zero: blank both results
    assign blank = (st_reg[NM] == qrr_pkg::ST_NONE) || (st_reg[NM] == qrr_pkg::ST_AZERO);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= vld_reg[NM];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ost_reg <= st_reg[NM];
            rp_reg  <= res[0];
            rm_reg  <= res[1];
        end
    end

    assign out_valid  = ov_reg;
    assign status     = ost_reg;
    assign root_plus  = rp_reg;
    assign root_minus = rm_reg;

endmodule

// ===== rtl/quadratic_real_roots_unit.sv =====
// Real roots of a*x^2 + b*x + c = 0, one coefficient set per request.
// Input channel coefs carries coef_a, coef_b, coef_c (signed, COEF_WIDTH
// bits). Output channel roots carries root_status (0 two roots, 1 double
// root, 2 no real root, 3 a is zero) and root_plus, root_minus in signed
// fixed point with FRAC_BITS fraction bits, zero when there is no root.
// Both channels move a request when valid and ready are high at a clock edge.
// Throughput is one request per cycle while roots.ready is not held low: the
// front multipliers, the square root (one bit per stage) and the two-lane
// divider (one quotient bit per stage) are all fully pipelined.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and coefs.ready drops until the result is taken; nothing is lost or
// repeated.
`include "quadratic_real_roots_unit_assert.svh"

module quadratic_real_roots_unit #(
    parameter int COEF_WIDTH = qrr_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrr_pkg::FRAC_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    qrr_coef_if.sink    coefs,
    qrr_root_if.source  roots
);

    localparam int DW  = qrr_pkg::disc_w(COEF_WIDTH);
    localparam int RWE = qrr_pkg::rad_w(COEF_WIDTH, FRAC_BITS);
    localparam int SQ  = qrr_pkg::sqrt_w(COEF_WIDTH, FRAC_BITS);
    localparam int NBW = qrr_pkg::nb_w(COEF_WIDTH, FRAC_BITS);
    localparam int NW  = qrr_pkg::num_w(COEF_WIDTH, FRAC_BITS);
    localparam int DM  = COEF_WIDTH + 1;
    localparam int SW  = 2 + NBW + DM;

    logic                  en;
    logic                  f_valid, s_valid;
    logic [RWE-1:0]        f_rad;
    logic signed [NBW-1:0] f_nb, s_nb;
    logic signed [DM-1:0]  f_den, s_den;
    logic [1:0]            f_st, s_st;
    logic [SQ-1:0]         s_root;
    logic [SW-1:0]         s_side;
    logic signed [NW-1:0]  nbx, rootx, num_p, num_m;

    // advance when the output register is free or being drained
    assign en          = roots.ready || !roots.valid;
    assign coefs.ready = en;

    qrr_front #(
        .CW  (COEF_WIDTH),
        .FB  (FRAC_BITS),
        .DW  (DW),
        .RWE (RWE),
        .NBW (NBW),
        .DM  (DM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coefs.valid),
        .a_in      (coefs.coef_a),
        .b_in      (coefs.coef_b),
        .c_in      (coefs.coef_c),
        .out_valid (f_valid),
        .rad       (f_rad),
        .nb        (f_nb),
        .den       (f_den),
        .status    (f_st)
    );

    qrr_sqrt #(
        .RWE (RWE),
        .SQ  (SQ),
        .SW  (SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .rad       (f_rad),
        .side_in   ({f_st, f_nb, f_den}),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    // form both numerators from -b and the square root
    always_comb
    begin
        s_st   = s_side[SW-1 -: 2];
        s_nb   = s_side[DM +: NBW];
        s_den  = s_side[DM-1:0];
        nbx    = NW'(s_nb);
        rootx  = NW'(s_root);
        num_p  = nbx + rootx;
        num_m  = nbx - rootx;
    end

    qrr_div #(
        .NW (NW),
        .DM (DM)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_valid),
        .num_p      (num_p),
        .num_m      (num_m),
        .den        (s_den),
        .status_in  (s_st),
        .out_valid  (roots.valid),
        .status     (roots.root_status),
        .root_plus  (roots.root_plus),
        .root_minus (roots.root_minus)
    );

    `QRR_ASSERT_IMPL(a_blank_roots, clk, rst_n,
        roots.valid && (roots.root_status == qrr_pkg::ST_NONE ||
                        roots.root_status == qrr_pkg::ST_AZERO),
        roots.root_plus == '0 && roots.root_minus == '0,
        "roots not zero without a real root")
    `QRR_ASSERT_IMPL(a_double_equal, clk, rst_n,
        roots.valid && roots.root_status == qrr_pkg::ST_DOUBLE,
        roots.root_plus == roots.root_minus,
        "double root with unequal roots")
    `QRR_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        roots.valid && !roots.ready,
        roots.valid && $stable(roots.root_plus) && $stable(roots.root_status),
        "stalled result changed")

endmodule
